/* design/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  `ASSERT_CLK(label, clk, rst, !(expr), msg)
`endif

/* design/mfmc_pkg.sv */
// shared constants, codes and types for the max flow engine
package mfmc_pkg;
  localparam int MAX_V   = 16;
  localparam int MAX_E   = 32;
  localparam int VW      = $clog2(MAX_V);
  localparam int VCW     = VW + 1;
  localparam int EIW     = $clog2(MAX_E);
  localparam int ECW     = EIW + 1;
  localparam int CAP_W   = 16;
  localparam int SLACK_W = CAP_W + 1;
  localparam int TOT_W   = 21;
  localparam int CFG_W   = 5;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_RUN   = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [1:0] REG_VCOUNT = 2'd0;
  localparam logic [1:0] REG_SOURCE = 2'd1;
  localparam logic [1:0] REG_SINK   = 2'd2;
  localparam logic [1:0] REG_NONE   = 2'd3;

  localparam logic [ECW-1:0] PRED_NONE = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_BFS_INIT,
    ST_POP,
    ST_SCAN,
    ST_AUG_INIT,
    ST_AUG,
    ST_SUM,
    ST_CUT
  } state_t;

  typedef struct packed {
    logic clr_edges;
    logic add_edge;
    logic clr_flow;
    logic emit_bad;
    logic bfs_init;
    logic pop;
    logic scan;
    logic aug_init;
    logic aug_step;
    logic sum_init;
    logic sum_step;
    logic cut_init;
    logic cut_step;
    logic emit_final;
  } dp_cmd_t;

  typedef struct packed {
    logic bad_term;
    logic q_nonempty;
    logic snk_reached;
    logic scan_done;
    logic aug_done;
    logic cut_done;
  } dp_stat_t;
endpackage

/* design/max_flow_min_cut_engine.sv */
// clear and add-edge requests are handled while idle and do not raise busy
// a run checks the terminals, then repeats a search and an augmentation along each path found,
// then sums the flow out of the source and scans for cut edges; it ends at once if terminals bad
// results come out one per cycle at most, the last result in the cycle busy drops
// rst is synchronous: edge table empty, overflow clear, registers back to 16, 0, 1
// there is no clearing pass after reset
module max_flow_min_cut_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 command,
  input  logic [mfmc_pkg::VW-1:0]    edge_from,
  input  logic [mfmc_pkg::VW-1:0]    edge_to,
  input  logic [mfmc_pkg::CAP_W-1:0] edge_capacity,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [mfmc_pkg::CFG_W-1:0] cfg_data,
  output logic                       valid,
  output logic                       kind,
  output logic [mfmc_pkg::TOT_W-1:0] total_flow,
  output logic [mfmc_pkg::VW-1:0]    cut_from,
  output logic [mfmc_pkg::VW-1:0]    cut_to,
  output logic                       overflow,
  output logic                       last
);
  mfmc_pkg::dp_cmd_t  cmd;
  mfmc_pkg::dp_stat_t stat;

  assign cfg_ready = !busy;

  mfmc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  mfmc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .edge_from     (edge_from),
    .edge_to       (edge_to),
    .edge_capacity (edge_capacity),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .valid         (valid),
    .kind          (kind),
    .total_flow    (total_flow),
    .cut_from      (cut_from),
    .cut_to        (cut_to),
    .overflow      (overflow),
    .last          (last)
  );
endmodule

/* design/mfmc_ctrl.sv */
// sequencer for edge loading, searches, augmentation, flow sum and cut report
module mfmc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        command,
  input  mfmc_pkg::dp_stat_t stat,
  output mfmc_pkg::dp_cmd_t  cmd,
  output logic              busy
);
  mfmc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mfmc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mfmc_pkg::ST_IDLE: begin
        if (start && command == mfmc_pkg::CMD_RUN) state_next = mfmc_pkg::ST_CHECK;
      end
      mfmc_pkg::ST_CHECK: begin
        state_next = stat.bad_term ? mfmc_pkg::ST_IDLE : mfmc_pkg::ST_BFS_INIT;
      end
      mfmc_pkg::ST_BFS_INIT: state_next = mfmc_pkg::ST_POP;
      mfmc_pkg::ST_POP: begin
        priority if (stat.snk_reached) state_next = mfmc_pkg::ST_AUG_INIT;
        else if (stat.q_nonempty)      state_next = mfmc_pkg::ST_SCAN;
        else                           state_next = mfmc_pkg::ST_SUM;
      end
      mfmc_pkg::ST_SCAN: begin
        if (stat.scan_done) state_next = mfmc_pkg::ST_POP;
      end
      mfmc_pkg::ST_AUG_INIT: state_next = mfmc_pkg::ST_AUG;
      mfmc_pkg::ST_AUG: begin
        if (stat.aug_done) state_next = mfmc_pkg::ST_BFS_INIT;
      end
      mfmc_pkg::ST_SUM: begin
        if (stat.scan_done) state_next = mfmc_pkg::ST_CUT;
      end
      mfmc_pkg::ST_CUT: begin
        if (stat.cut_done) state_next = mfmc_pkg::ST_IDLE;
      end
      default: state_next = mfmc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != mfmc_pkg::ST_IDLE);
    unique case (state)
      mfmc_pkg::ST_IDLE: begin
        cmd.clr_edges = start && command == mfmc_pkg::CMD_CLEAR;
        cmd.add_edge  = start && command == mfmc_pkg::CMD_ADD;
      end
      mfmc_pkg::ST_CHECK: begin
        cmd.emit_bad = stat.bad_term;
        cmd.clr_flow = !stat.bad_term;
      end
      mfmc_pkg::ST_BFS_INIT: cmd.bfs_init = 1'b1;
      mfmc_pkg::ST_POP: begin
        cmd.pop      = !stat.snk_reached && stat.q_nonempty;
        cmd.sum_init = !stat.snk_reached && !stat.q_nonempty;
      end
      mfmc_pkg::ST_SCAN:     cmd.scan = !stat.scan_done;
      mfmc_pkg::ST_AUG_INIT: cmd.aug_init = 1'b1;
      mfmc_pkg::ST_AUG:      cmd.aug_step = !stat.aug_done;
      mfmc_pkg::ST_SUM: begin
        cmd.sum_step = !stat.scan_done;
        cmd.cut_init = stat.scan_done;
      end
      mfmc_pkg::ST_CUT: begin
        cmd.cut_step   = !stat.cut_done;
        cmd.emit_final = stat.cut_done;
      end
      default: cmd = '0;
    endcase
  end
endmodule

/* design/mfmc_dp.sv */
// edge table, search state, flow arithmetic and result registers
module mfmc_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  mfmc_pkg::dp_cmd_t            cmd,
  output mfmc_pkg::dp_stat_t           stat,
  input  logic [mfmc_pkg::VW-1:0]      edge_from,
  input  logic [mfmc_pkg::VW-1:0]      edge_to,
  input  logic [mfmc_pkg::CAP_W-1:0]   edge_capacity,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [mfmc_pkg::CFG_W-1:0]   cfg_data,
  output logic                         valid,
  output logic                         kind,
  output logic [mfmc_pkg::TOT_W-1:0]   total_flow,
  output logic [mfmc_pkg::VW-1:0]      cut_from,
  output logic [mfmc_pkg::VW-1:0]      cut_to,
  output logic                         overflow,
  output logic                         last
);
  localparam int VW  = mfmc_pkg::VW;
  localparam int VCW = mfmc_pkg::VCW;
  localparam int EIW = mfmc_pkg::EIW;
  localparam int ECW = mfmc_pkg::ECW;
  localparam int CW  = mfmc_pkg::CAP_W;
  localparam int SW  = mfmc_pkg::SLACK_W;
  localparam int TW  = mfmc_pkg::TOT_W;
  localparam int NV  = mfmc_pkg::MAX_V;

  // configuration
  logic [VCW-1:0] vcount;
  logic [VW-1:0]  src, snk;

  // edge table
  logic [VW-1:0] etail [mfmc_pkg::MAX_E];
  logic [VW-1:0] ehead [mfmc_pkg::MAX_E];
  logic [CW-1:0] ecap  [mfmc_pkg::MAX_E];
  logic [CW-1:0] eflow [mfmc_pkg::MAX_E];
  logic [ECW-1:0] ecount;
  logic           ovf_flag;

  // per-vertex search state
  logic [mfmc_pkg::MAX_V-1:0] reached;
  logic [ECW-1:0] pred  [mfmc_pkg::MAX_V];
  logic [SW-1:0]  slack [mfmc_pkg::MAX_V];
  logic [VW-1:0]  queue [mfmc_pkg::MAX_V];
  logic [VCW-1:0] qhead, qtail;

  logic [VW-1:0]  x;
  logic [ECW-1:0] eidx;
  logic [VCW-1:0] vidx;
  logic [VCW-1:0] steps;
  logic [CW-1:0]  bneck;
  logic [TW-1:0]  sum;

  // held result, sent once the next one is known
  logic          pkind;
  logic [TW-1:0] ptotal;
  logic [VW-1:0] pfrom, pto;

  logic [VCW-1:0] n;
  logic [EIW-1:0] ea;
  logic [VW-1:0]  tl, hd, y;
  logic [CW-1:0]  cap, flw, s;
  logic           live, fwd, bwd, take, cut_hit;
  logic [VW-1:0]  sidx;
  logic [SW-1:0]  sx, sext, smin;
  logic [ECW-1:0] px;

  assign n  = (vcount > VCW'(mfmc_pkg::MAX_V)) ? VCW'(mfmc_pkg::MAX_V) : vcount;
  assign px = pred[x];
  assign ea = cmd.aug_step ? px[EIW-1:0] : eidx[EIW-1:0];
  assign tl  = etail[ea];
  assign hd  = ehead[ea];
  assign cap = ecap[ea];
  assign flw = eflow[ea];
  assign live = ({1'b0, tl} < n) && ({1'b0, hd} < n);
  assign fwd  = (tl == x);
  assign bwd  = (hd == x);
  assign y    = fwd ? hd : tl;
  assign s    = fwd ? cap - flw : flw;
  assign take = live && (fwd || bwd) && !reached[y] && (s != '0);
  assign sidx = cmd.aug_init ? snk : x;
  assign sx   = slack[sidx];
  assign sext = {1'b0, s};
  assign smin = (sx < sext) ? sx : sext;
  assign cut_hit = live && (tl == vidx[VW-1:0]) && !reached[hd];

  assign stat.bad_term    = ({1'b0, src} >= n) || ({1'b0, snk} >= n) || (src == snk);
  assign stat.q_nonempty  = (qhead < qtail);
  assign stat.snk_reached = reached[snk];
  assign stat.scan_done   = (eidx == ecount);
  assign stat.aug_done    = (x == src) || (steps >= n) || (px >= ecount);
  assign stat.cut_done    = (vidx == n);

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= VCW'(mfmc_pkg::MAX_V);
      src    <= '0;
      snk    <= VW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        mfmc_pkg::REG_VCOUNT: vcount <= cfg_data;
        mfmc_pkg::REG_SOURCE: src    <= cfg_data[VW-1:0];
        mfmc_pkg::REG_SINK:   snk    <= cfg_data[VW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ecount   <= '0;
      ovf_flag <= 1'b0;
    end else if (cmd.clr_edges) begin
      ecount <= '0;
    end else if (cmd.add_edge && edge_from != edge_to) begin
      if (ecount >= ECW'(mfmc_pkg::MAX_E)) begin
        ovf_flag <= 1'b1;
      end else begin
        ecount <= ecount + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_edge && edge_from != edge_to && ecount < ECW'(mfmc_pkg::MAX_E)) begin
      etail[ecount[EIW-1:0]] <= edge_from;
      ehead[ecount[EIW-1:0]] <= edge_to;
      ecap[ecount[EIW-1:0]]  <= edge_capacity;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_flow) begin
      for (int i = 0; i < mfmc_pkg::MAX_E; i++) eflow[i] <= '0;
    end else if (cmd.aug_step) begin
      if (hd == x) eflow[ea] <= flw + bneck;
      else         eflow[ea] <= flw - bneck;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bfs_init) begin
      // only the source starts out reached
      reached      <= NV'(1) << src;
      slack[src]   <= SW'(1) << CW;
      queue[0]     <= src;
      qhead        <= '0;
      qtail        <= VCW'(1);
    end else if (cmd.pop) begin
      x     <= queue[qhead[VW-1:0]];
      qhead <= qhead + 1'b1;
      eidx  <= '0;
    end else if (cmd.scan) begin
      eidx <= eidx + 1'b1;
      if (take) begin
        slack[y]   <= smin;
        pred[y]    <= eidx;
        reached[y] <= 1'b1;
        if (qtail < VCW'(mfmc_pkg::MAX_V)) begin
          queue[qtail[VW-1:0]] <= y;
          qtail <= qtail + 1'b1;
        end
      end
    end else if (cmd.aug_init) begin
      x     <= snk;
      bneck <= sx[CW-1:0];
      steps <= '0;
    end else if (cmd.aug_step) begin
      x     <= (hd == x) ? tl : hd;
      steps <= steps + 1'b1;
    end else if (cmd.sum_init) begin
      eidx <= '0;
      sum  <= '0;
    end else if (cmd.sum_step) begin
      eidx <= eidx + 1'b1;
      if (live && tl == src) sum <= sum + TW'(flw);
    end else if (cmd.cut_init) begin
      vidx <= '0;
      eidx <= '0;
    end else if (cmd.cut_step) begin
      if (!reached[vidx[VW-1:0]] || eidx == ecount) begin
        vidx <= vidx + 1'b1;
        eidx <= '0;
      end else begin
        eidx <= eidx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cmd.emit_bad || cmd.emit_final ||
               (cmd.cut_step && reached[vidx[VW-1:0]] && eidx != ecount && cut_hit);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cut_init) begin
      pkind  <= 1'b0;
      ptotal <= sum;
      pfrom  <= '0;
      pto    <= '0;
    end
    if (cmd.emit_bad) begin
      kind       <= 1'b0;
      total_flow <= '0;
      cut_from   <= '0;
      cut_to     <= '0;
      overflow   <= ovf_flag;
      last       <= 1'b1;
    end else if (cmd.emit_final) begin
      kind       <= pkind;
      total_flow <= ptotal;
      cut_from   <= pfrom;
      cut_to     <= pto;
      overflow   <= ovf_flag;
      last       <= 1'b1;
    end else if (cmd.cut_step && reached[vidx[VW-1:0]] && eidx != ecount && cut_hit) begin
      kind       <= pkind;
      total_flow <= ptotal;
      cut_from   <= pfrom;
      cut_to     <= pto;
      overflow   <= ovf_flag;
      last       <= 1'b0;
      pkind      <= 1'b1;
      ptotal     <= '0;
      pfrom      <= tl;
      pto        <= hd;
    end
  end
endmodule

/* design/mfmc_chk.sv */
// port-level checks for the max flow engine, bound to the top level
`include "assert_macros.svh"
module mfmc_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       valid,
  input logic                       kind,
  input logic [mfmc_pkg::TOT_W-1:0] total_flow,
  input logic [mfmc_pkg::VW-1:0]    cut_from,
  input logic [mfmc_pkg::VW-1:0]    cut_to,
  input logic                       last
);
  `ASSERT_CLK(a_gap_after_last, clk, rst, valid && last |=> !valid, "result right after last")
  `ASSERT_CLK(a_busy_mid_run, clk, rst, valid && !last |-> busy, "run ended before last result")
  `ASSERT_CLK(a_no_result_on_accept, clk, rst, start && !busy |=> !valid, "result too soon after request")
  `ASSERT_NEVER(a_cut_fields, clk, rst, valid && kind && total_flow != '0, "cut result with flow")
  `ASSERT_NEVER(a_total_fields, clk, rst, valid && !kind && (cut_from != '0 || cut_to != '0),
    "flow result with edge")
endmodule

bind max_flow_min_cut_engine mfmc_chk u_chk (.*);

/* tb/max_flow_min_cut_engine_tb.sv */
// testbench for the max flow / min cut engine: random graphs checked against a predictor
module max_flow_min_cut_engine_tb;
  localparam int MAX_V = mfmc_pkg::MAX_V;
  localparam int MAX_E = mfmc_pkg::MAX_E;
  localparam int VW    = mfmc_pkg::VW;
  localparam int CAP_W = mfmc_pkg::CAP_W;
  localparam int TOT_W = mfmc_pkg::TOT_W;
  localparam int CFG_W = mfmc_pkg::CFG_W;

  class flow_scoreboard;
    typedef struct {
      bit          kind;
      int unsigned total;
      int unsigned from_v;
      int unsigned to_v;
      bit          ovf;
      bit          last;
    } flow_result_t;

    int unsigned  vcount = 16;
    int unsigned  src_v = 0;
    int unsigned  snk_v = 1;
    int unsigned  tail_v[MAX_E];
    int unsigned  head_v[MAX_E];
    int unsigned  cap[MAX_E];
    int unsigned  flow[MAX_E];
    int unsigned  ecount = 0;
    bit           ovf_flag = 0;
    bit           seen[MAX_V];
    int unsigned  pred[MAX_V];
    int unsigned  slack[MAX_V];
    flow_result_t pending[$];
    int           errors = 0;

    function void set_reg(logic [1:0] idx, int unsigned val);
      if (idx == mfmc_pkg::REG_VCOUNT) vcount = val & 31;
      else if (idx == mfmc_pkg::REG_SOURCE) src_v = val & 15;
      else if (idx == mfmc_pkg::REG_SINK) snk_v = val & 15;
    endfunction

    function bit live(int unsigned e, int unsigned n);
      return tail_v[e] < n && head_v[e] < n;
    endfunction

    function bit bfs(int unsigned n);
      int unsigned q[$];
      int unsigned x, y, s;
      for (int v = 0; v < MAX_V; v++) begin
        seen[v] = 0;
        pred[v] = mfmc_pkg::PRED_NONE;
      end
      seen[src_v] = 1;
      slack[src_v] = 1 << CAP_W;
      q = {q, src_v};
      while (q.size() != 0 && !seen[snk_v]) begin
        x = q.pop_front();
        for (int e = 0; e < ecount; e++) begin
          if (!live(e, n)) continue;
          if (tail_v[e] == x) begin
            y = head_v[e];
            s = cap[e] - flow[e];
          end else if (head_v[e] == x) begin
            y = tail_v[e];
            s = flow[e];
          end else begin
            continue;
          end
          if (seen[y] || s == 0) continue;
          slack[y] = slack[x] < s ? slack[x] : s;
          pred[y] = e;
          seen[y] = 1;
          q = {q, y};
        end
      end
      return seen[snk_v];
    endfunction

    function void push_path(int unsigned n);
      int unsigned x, e, steps, b;
      x = snk_v;
      steps = 0;
      b = slack[snk_v];
      while (x != src_v && steps < n) begin
        e = pred[x];
        if (e >= ecount) break;
        if (head_v[e] == x) begin
          flow[e] += b;
          x = tail_v[e];
        end else begin
          flow[e] -= b;
          x = head_v[e];
        end
        steps++;
      end
    endfunction

    function void expect_result(bit kind, int unsigned total, int unsigned f, int unsigned t);
      flow_result_t r;
      r.kind = kind;
      r.total = total;
      r.from_v = f;
      r.to_v = t;
      r.ovf = ovf_flag;
      r.last = 0;
      pending = {pending, r};
    endfunction

    function void note_request(logic [1:0] cmd, int unsigned a, int unsigned b,
                               int unsigned c);
      int unsigned n, total;
      if (cmd == mfmc_pkg::CMD_CLEAR) begin
        ecount = 0;
      end else if (cmd == mfmc_pkg::CMD_ADD) begin
        if (a == b) return;
        if (ecount >= MAX_E) begin
          ovf_flag = 1;
          return;
        end
        tail_v[ecount] = a;
        head_v[ecount] = b;
        cap[ecount] = c & 16'hffff;
        flow[ecount] = 0;
        ecount++;
      end else if (cmd == mfmc_pkg::CMD_RUN) begin
        n = vcount > MAX_V ? MAX_V : vcount;
        if (src_v >= n || snk_v >= n || src_v == snk_v) begin
          expect_result(0, 0, 0, 0);
        end else begin
          for (int e = 0; e < ecount; e++) flow[e] = 0;
          while (bfs(n)) push_path(n);
          total = 0;
          for (int e = 0; e < ecount; e++)
            if (live(e, n) && tail_v[e] == src_v) total += flow[e];
          expect_result(0, total & 21'h1fffff, 0, 0);
          for (int v = 0; v < n; v++) begin
            if (!seen[v]) continue;
            for (int e = 0; e < ecount; e++)
              if (live(e, n) && tail_v[e] == v && !seen[head_v[e]])
                expect_result(1, 0, tail_v[e], head_v[e]);
          end
        end
        pending[$].last = 1;
      end
    endfunction

    function void check_result(bit kind, int unsigned total, int unsigned f,
                               int unsigned t, bit ovf, bit last);
      flow_result_t r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result kind=%0d total=%0d cut=%0d->%0d",
                 $time, kind, total, f, t);
        errors++;
        return;
      end
      r = pending.pop_front();
      if (kind != r.kind || total != r.total || f != r.from_v || t != r.to_v ||
          ovf != r.ovf || last != r.last) begin
        $display("%0t: mismatch expected kind=%0d total=%0d cut=%0d->%0d ovf=%0d last=%0d",
                 $time, r.kind, r.total, r.from_v, r.to_v, r.ovf, r.last);
        $display("%0t:          actual   kind=%0d total=%0d cut=%0d->%0d ovf=%0d last=%0d",
                 $time, kind, total, f, t, ovf, last);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 0;
  logic             rst = 1;
  logic             start = 0;
  logic             busy;
  logic [1:0]       command = mfmc_pkg::CMD_CLEAR;
  logic [VW-1:0]    edge_from = '0;
  logic [VW-1:0]    edge_to = '0;
  logic [CAP_W-1:0] edge_capacity = '0;
  logic             cfg_valid = 0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = mfmc_pkg::REG_VCOUNT;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             valid;
  logic             kind;
  logic [TOT_W-1:0] total_flow;
  logic [VW-1:0]    cut_from;
  logic [VW-1:0]    cut_to;
  logic             overflow;
  logic             last;

  flow_scoreboard sb = new();
  bit             quiet = 0;
  int             request_count = 0;

  max_flow_min_cut_engine i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .edge_from(edge_from), .edge_to(edge_to), .edge_capacity(edge_capacity),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .valid(valid), .kind(kind), .total_flow(total_flow),
    .cut_from(cut_from), .cut_to(cut_to), .overflow(overflow), .last(last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #500000000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && valid) sb.check_result(kind, total_flow, cut_from, cut_to, overflow, last);
  end

  task automatic send_request(logic [1:0] cmd, int unsigned a, int unsigned b,
                              int unsigned c);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start <= 1;
    command <= cmd;
    edge_from <= VW'(a);
    edge_to <= VW'(b);
    edge_capacity <= CAP_W'(c);
    do @(posedge clk); while (busy);
    sb.note_request(cmd, a, b, c);
    request_count++;
  endtask

  task automatic wait_idle();
    start <= 0;
    while (sb.pending.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_graph_regs(int unsigned n, int unsigned s, int unsigned t);
    wait_idle();
    write_reg(mfmc_pkg::REG_VCOUNT, n);
    write_reg(mfmc_pkg::REG_SOURCE, s);
    write_reg(mfmc_pkg::REG_SINK, t);
  endtask

  task automatic random_phase();
    int unsigned n, s, t, edges, a, b, c, pick;
    pick = $urandom_range(0, 9);
    n = pick < 8 ? $urandom_range(2, 8) : (pick == 8 ? 16 : $urandom_range(0, 31));
    if ($urandom_range(0, 7) == 0) begin
      s = $urandom_range(0, 15);
      t = $urandom_range(0, 15);
    end else begin
      s = $urandom_range(0, (n > 16 ? 16 : (n < 2 ? 2 : n)) - 1);
      t = $urandom_range(0, (n > 16 ? 16 : (n < 2 ? 2 : n)) - 1);
    end
    set_graph_regs(n, s, t);
    send_request(mfmc_pkg::CMD_CLEAR, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
    edges = $urandom_range(0, 11) == 0 ? 34 : $urandom_range(1, 12);
    for (int i = 0; i < edges; i++) begin
      if ($urandom_range(0, 6) == 0 || n < 2) begin
        a = $urandom_range(0, 15);
        b = $urandom_range(0, 15);
      end else begin
        a = $urandom_range(0, (n > 16 ? 16 : n) - 1);
        b = $urandom_range(0, (n > 16 ? 16 : n) - 1);
      end
      pick = $urandom_range(0, 9);
      c = pick < 5 ? $urandom_range(1, 20) : (pick == 9 ? 0 : $urandom_range(0, 65535));
      send_request(mfmc_pkg::CMD_ADD, a, b, c);
      if ($urandom_range(0, 19) == 0)
        send_request(mfmc_pkg::CMD_NOP, $urandom_range(0, 15), $urandom_range(0, 15),
                     $urandom);
    end
    send_request(mfmc_pkg::CMD_RUN, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
    if ($urandom_range(0, 3) == 0)
      send_request(mfmc_pkg::CMD_RUN, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // registers at reset: 16 vertices, source 0, sink 1
    send_request(mfmc_pkg::CMD_ADD, 0, 1, 16'hffff);
    send_request(mfmc_pkg::CMD_ADD, 0, 2, 0);
    send_request(mfmc_pkg::CMD_ADD, 2, 2, 7);
    send_request(mfmc_pkg::CMD_ADD, 1, 0, 1);
    send_request(mfmc_pkg::CMD_ADD, 0, 3, 9);
    send_request(mfmc_pkg::CMD_ADD, 3, 1, 5);
    send_request(mfmc_pkg::CMD_ADD, 15, 14, 16'haaaa);
    send_request(mfmc_pkg::CMD_NOP, 4'ha, 4'h5, 16'h5555);
    send_request(mfmc_pkg::CMD_RUN, 0, 0, 0);
    send_request(mfmc_pkg::CMD_RUN, 15, 15, 16'hffff);
    send_request(mfmc_pkg::CMD_CLEAR, 0, 0, 0);
    send_request(mfmc_pkg::CMD_RUN, 0, 0, 0);
    // top vertices with an edge past the vertices in use
    set_graph_regs(31, 15, 14);
    wait_idle();
    write_reg(mfmc_pkg::REG_NONE, 5'h1f);
    send_request(mfmc_pkg::CMD_ADD, 15, 14, 16'h8001);
    send_request(mfmc_pkg::CMD_ADD, 15, 13, 3);
    send_request(mfmc_pkg::CMD_ADD, 13, 14, 2);
    send_request(mfmc_pkg::CMD_RUN, 0, 0, 0);
    set_graph_regs(14, 15, 13);
    send_request(mfmc_pkg::CMD_RUN, 0, 0, 0);
    set_graph_regs(0, 0, 0);
    send_request(mfmc_pkg::CMD_RUN, 0, 0, 0);
    set_graph_regs(1, 0, 0);
    send_request(mfmc_pkg::CMD_RUN, 0, 0, 0);
    set_graph_regs(16, 3, 3);
    send_request(mfmc_pkg::CMD_RUN, 0, 0, 0);

    while (request_count < 170) begin
      if (request_count > 145) quiet = 1;
      random_phase();
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
